[rtl/core/qte_pkg.sv]
// Shared widths, constants and the CORDIC angle table for the quaternion to Euler block.
`default_nettype none
package qte_pkg;

	localparam int COMPONENT_WIDTH_DEF = 16;
	localparam int CORDIC_STAGES_DEF   = 16;

	localparam int WORK_FRAC  = 20;
	localparam int Q_W        = 22;
	localparam int PROD_W     = 44;
	localparam int SUM_W      = 46;
	localparam int A30_W      = 32;
	localparam int SQ_W       = 61;
	localparam int ROOT_W     = 31;
	localparam int ISQ_STAGES = 31;
	localparam int ARG_W      = 50;
	localparam int Z_W        = 33;
	localparam int TABLE_LEN  = 30;

	localparam logic signed [SUM_W-1:0] ONE_Q40 = SUM_W'(64'sd1 <<< 40);
	localparam logic signed [Z_W-1:0] HALF_TURN = 33'sd1179648000;

	// atan(2^-i) in centidegrees, Q.16
	localparam logic signed [Z_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
		33'sd294912000, 33'sd174096719, 33'sd91987925, 33'sd46694507,
		33'sd23437865, 33'sd11730358, 33'sd5866610, 33'sd2933484,
		33'sd1466764, 33'sd733385, 33'sd366693, 33'sd183346,
		33'sd91673, 33'sd45837, 33'sd22918, 33'sd11459,
		33'sd5730, 33'sd2865, 33'sd1432, 33'sd716,
		33'sd358, 33'sd179, 33'sd90, 33'sd45,
		33'sd22, 33'sd11, 33'sd6, 33'sd3,
		33'sd1, 33'sd1
	};

	typedef struct packed {
		logic signed [SUM_W-1:0] ry;
		logic signed [SUM_W-1:0] rx;
		logic signed [SUM_W-1:0] yy;
		logic signed [SUM_W-1:0] yx;
		logic signed [A30_W-1:0] a30;
		logic                    clamped;
	} side_t;

endpackage
`default_nettype wire

[rtl/core/qte_isqrt.sv]
// Pipelined floor integer square root, one result bit per stage.
`default_nettype none
module qte_isqrt (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [qte_pkg::SQ_W-1:0]    radicand,
	output logic      [qte_pkg::ROOT_W-1:0]  root
);
	localparam int N = qte_pkg::ISQ_STAGES;
	localparam int W = qte_pkg::SQ_W;

	logic [W-1:0] rem_s [N];
	logic [W-1:0] rt_s  [N];

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam logic [W:0] BIT = (W+1)'(1) << (2 * (N - 1 - j));
		logic [W-1:0] rem_p;
		logic [W-1:0] rt_p;
		logic [W:0]   trial;
		logic         ge;

		if (j == 0) begin : g_first
			assign rem_p = radicand;
			assign rt_p  = '0;
		end else begin : g_next
			assign rem_p = rem_s[j-1];
			assign rt_p  = rt_s[j-1];
		end

		assign trial = {1'b0, rt_p} + BIT;
		assign ge    = {1'b0, rem_p} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				if (ge) begin
					rem_s[j] <= W'({1'b0, rem_p} - trial);
					rt_s[j]  <= W'(({1'b0, rt_p} >> 1) + BIT);
				end else begin
					rem_s[j] <= rem_p;
					rt_s[j]  <= rt_p >> 1;
				end
			end
		end
	end

	assign root = rt_s[N-1][qte_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

[rtl/core/qte_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) in centidegrees, Q.16.
`default_nettype none
module qte_cordic #(
	parameter int STAGES = qte_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [qte_pkg::ARG_W-1:0]  x,
	input  wire logic signed [qte_pkg::ARG_W-1:0]  y,
	output logic signed      [qte_pkg::Z_W-1:0]    angle
);
	localparam int AW = qte_pkg::ARG_W;
	localparam int N  = (STAGES > qte_pkg::TABLE_LEN) ? qte_pkg::TABLE_LEN : STAGES;

	logic signed [AW-1:0]          x_s    [N+1];
	logic signed [AW-1:0]          y_s    [N+1];
	logic signed [qte_pkg::Z_W-1:0] z_s    [N+1];
	logic                          zero_s [N+1];

	// fold the left half plane onto the right one
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x == '0) && (y == '0);
			if (x[AW-1]) begin
				x_s[0] <= -x;
				y_s[0] <= -y;
				z_s[0] <= y[AW-1] ? -qte_pkg::HALF_TURN : qte_pkg::HALF_TURN;
			end else begin
				x_s[0] <= x;
				y_s[0] <= y;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic signed [AW-1:0] xs;
		logic signed [AW-1:0] ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][AW-1]) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + qte_pkg::ATAN_TABLE[i];
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - qte_pkg::ATAN_TABLE[i];
				end
			end
		end
	end

	assign angle = zero_s[N] ? '0 : z_s[N];

endmodule
`default_nettype wire

[rtl/core/quaternion_to_euler_angles.sv]
// Top level: quaternion in, ZYX roll, pitch and yaw in centidegrees out.
//
//   channel  | handshake             | payload
//   request  | in_valid / in_stall   | quat_w, quat_x, quat_y, quat_z
//   result   | out_valid / out_stall | roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One request enters per cycle while in_stall is low. CORDIC_STAGES is capped at 30.
// Each request passes through three product/sum stages, the 31 square-root bit stages
// feeding the pitch CORDIC, the CORDIC half-plane fold stage, the CORDIC rotation
// stages and the output stage.
// Reset clears only the valid bits. A stalled result freezes the whole pipeline,
// and in_stall follows it in the same cycle.
`default_nettype none
module quaternion_to_euler_angles #(
	parameter int COMPONENT_WIDTH = qte_pkg::COMPONENT_WIDTH_DEF,
	parameter int CORDIC_STAGES   = qte_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [COMPONENT_WIDTH-1:0] quat_w,
	input  wire logic signed [COMPONENT_WIDTH-1:0] quat_x,
	input  wire logic signed [COMPONENT_WIDTH-1:0] quat_y,
	input  wire logic signed [COMPONENT_WIDTH-1:0] quat_z,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [15:0]                     roll_angle,
	output logic signed [14:0]                     pitch_angle,
	output logic signed [15:0]                     yaw_angle,
	output logic                                   pitch_clamped
);
	localparam int QW   = qte_pkg::Q_W;
	localparam int PW   = qte_pkg::PROD_W;
	localparam int SW   = qte_pkg::SUM_W;
	localparam int AW   = qte_pkg::ARG_W;
	localparam int ZW   = qte_pkg::Z_W;
	localparam int NISQ = qte_pkg::ISQ_STAGES;
	localparam int NCOR = (CORDIC_STAGES > qte_pkg::TABLE_LEN) ?
		qte_pkg::TABLE_LEN : CORDIC_STAGES;
	localparam int LAT  = 5 + NISQ + NCOR;

	logic en;
	logic [LAT-1:0] vld_q;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// bring components to Q.20
	logic signed [QW-1:0] q0, q1, q2, q3;

	if (COMPONENT_WIDTH <= QW) begin : g_widen
		assign q0 = QW'(quat_w) <<< (QW - COMPONENT_WIDTH);
		assign q1 = QW'(quat_x) <<< (QW - COMPONENT_WIDTH);
		assign q2 = QW'(quat_y) <<< (QW - COMPONENT_WIDTH);
		assign q3 = QW'(quat_z) <<< (QW - COMPONENT_WIDTH);
	end else begin : g_narrow
		assign q0 = QW'(quat_w >>> (COMPONENT_WIDTH - QW));
		assign q1 = QW'(quat_x >>> (COMPONENT_WIDTH - QW));
		assign q2 = QW'(quat_y >>> (COMPONENT_WIDTH - QW));
		assign q3 = QW'(quat_z >>> (COMPONENT_WIDTH - QW));
	end

	// stage 1: products
	logic signed [PW-1:0] p01_s1, p23_s1, p11_s1, p22_s1, p12_s1, p03_s1, p33_s1;
	logic signed [PW-1:0] p02_s1, p13_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p01_s1 <= q0 * q1;
			p23_s1 <= q2 * q3;
			p11_s1 <= q1 * q1;
			p22_s1 <= q2 * q2;
			p12_s1 <= q1 * q2;
			p03_s1 <= q0 * q3;
			p33_s1 <= q3 * q3;
			p02_s1 <= q0 * q2;
			p13_s1 <= q1 * q3;
		end
	end

	// stage 2: sums and asin clamp
	logic signed [SW-1:0] a_raw, a_cl;
	logic                 clamp_c;

	always_comb begin
		a_raw   = (SW'(p02_s1) - SW'(p13_s1)) <<< 1;
		a_cl    = a_raw;
		clamp_c = 1'b0;
		if (a_raw > qte_pkg::ONE_Q40) begin
			a_cl    = qte_pkg::ONE_Q40;
			clamp_c = 1'b1;
		end else if (a_raw < -qte_pkg::ONE_Q40) begin
			a_cl    = -qte_pkg::ONE_Q40;
			clamp_c = 1'b1;
		end
	end

	qte_pkg::side_t side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.ry      <= (SW'(p01_s1) + SW'(p23_s1)) <<< 1;
			side_s2.rx      <= qte_pkg::ONE_Q40 - ((SW'(p11_s1) + SW'(p22_s1)) <<< 1);
			side_s2.yy      <= (SW'(p12_s1) + SW'(p03_s1)) <<< 1;
			side_s2.yx      <= qte_pkg::ONE_Q40 - ((SW'(p22_s1) + SW'(p33_s1)) <<< 1);
			side_s2.a30     <= qte_pkg::A30_W'(a_cl >>> 10);
			side_s2.clamped <= clamp_c;
		end
	end

	// stage 3: radicand 1 - a^2 in Q.60
	logic signed [63:0] sq;
	logic [qte_pkg::SQ_W-1:0] rad_s3;
	qte_pkg::side_t side_s3;

	assign sq = side_s2.a30 * side_s2.a30;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3  <= qte_pkg::SQ_W'((64'sd1 <<< 60) - sq);
			side_s3 <= side_s2;
		end
	end

	logic [qte_pkg::ROOT_W-1:0] root;

	qte_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (rad_s3),
		.root     (root)
	);

	// hold the side terms alongside the square root
	qte_pkg::side_t side_q [NISQ];

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_s3;
			for (int k = 1; k < NISQ; k++) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	qte_pkg::side_t side_d;
	assign side_d = side_q[NISQ-1];

	logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;

	qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
		.clk   (clk),
		.en    (en),
		.x     (AW'(side_d.rx)),
		.y     (AW'(side_d.ry)),
		.angle (roll_z)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
		.clk   (clk),
		.en    (en),
		.x     (AW'(signed'({1'b0, root}))),
		.y     (AW'(side_d.a30)),
		.angle (pitch_z)
	);

	qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
		.clk   (clk),
		.en    (en),
		.x     (AW'(side_d.yx)),
		.y     (AW'(side_d.yy)),
		.angle (yaw_z)
	);

	// carry the clamp flag through the CORDIC stages
	logic clamp_q [NCOR+1];

	always_ff @(posedge clk) begin
		if (en) begin
			clamp_q[0] <= side_d.clamped;
			for (int k = 1; k <= NCOR; k++) begin
				clamp_q[k] <= clamp_q[k-1];
			end
		end
	end

	// round half up to whole centidegrees, then saturate
	function automatic logic signed [17:0] to_centi(
		input logic signed [ZW-1:0] z,
		input logic signed [17:0]   limit
	);
		logic signed [ZW:0]  zr;
		logic signed [17:0]  c;
		zr = (ZW+1)'(z) + (ZW+1)'(32768);
		c  = 18'(zr >>> 16);
		if (c > limit) begin
			c = limit;
		end else if (c < -limit) begin
			c = -limit;
		end
		return c;
	endfunction

	logic signed [17:0] roll_c, pitch_c, yaw_c;

	assign roll_c  = to_centi(roll_z, 18'sd18000);
	assign pitch_c = to_centi(pitch_z, 18'sd9000);
	assign yaw_c   = to_centi(yaw_z, 18'sd18000);

	always_ff @(posedge clk) begin
		if (en) begin
			roll_angle    <= roll_c[15:0];
			pitch_angle   <= pitch_c[14:0];
			yaw_angle     <= yaw_c[15:0];
			pitch_clamped <= clamp_q[NCOR];
		end
	end

endmodule
`default_nettype wire

[rtl/core/qte_checker.sv]
// Port-level checks for the quaternion to Euler block, bound to the top level.
`default_nettype none
module qte_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [15:0] roll_angle,
	input wire logic signed [14:0] pitch_angle,
	input wire logic signed [15:0] yaw_angle,
	input wire logic               pitch_clamped
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(roll_angle) && $stable(pitch_angle) &&
			$stable(yaw_angle) && $stable(pitch_clamped))
		else $error("stalled result changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("request stall does not follow result stall");

	a_clamp_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pitch_clamped |-> pitch_angle == 15'sd9000 || pitch_angle == -15'sd9000)
		else $error("clamped asin did not give a right angle");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> roll_angle <= 16'sd18000 && roll_angle >= -16'sd18000 &&
			yaw_angle <= 16'sd18000 && yaw_angle >= -16'sd18000 &&
			pitch_angle <= 15'sd9000 && pitch_angle >= -15'sd9000)
		else $error("angle out of range");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);
`default_nettype wire
